// File: rtl/yrp_pkg.sv
// ----------------------------------------------------------------------------
// yrp_pkg
// Shared types and constants for the YUV to ARGB rotate-and-place block.
// ----------------------------------------------------------------------------
package yrp_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int COORD_W    = 12;
	localparam int ROT_W      = 2;
	localparam int FRAME_W    = 13;
	localparam int OFFSET_W   = 14;
	localparam int POS_W      = 15;
	localparam int ARGB_W     = 32;
	localparam int ADDR_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int CHAN_W     = 22;

	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_OFFSET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_OFFSET = 3'd4;

	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

	localparam logic [FRAME_W-1:0] FRAME_RST = 13'd4096;

	localparam logic [SAMPLE_W-1:0] LUMA_OFS   = 8'd16;
	localparam logic [SAMPLE_W-1:0] ALPHA      = 8'hff;
	localparam logic signed [CHAN_W-1:0] CHROMA_OFS = 22'sd128;
	localparam logic signed [CHAN_W-1:0] K_Y    = 22'sd1192;
	localparam logic signed [CHAN_W-1:0] K_VR   = 22'sd1634;
	localparam logic signed [CHAN_W-1:0] K_VG   = 22'sd833;
	localparam logic signed [CHAN_W-1:0] K_UG   = 22'sd400;
	localparam logic signed [CHAN_W-1:0] K_UB   = 22'sd2066;
	localparam logic signed [CHAN_W-1:0] CHAN_MAX = 22'sd262143;
	localparam int CHAN_SHIFT = 10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] luma;
		logic [SAMPLE_W-1:0] chroma_u;
		logic [SAMPLE_W-1:0] chroma_v;
		logic [COORD_W-1:0]  src_col;
		logic [COORD_W-1:0]  src_row;
	} pix_t;

	typedef struct packed {
		logic [ARGB_W-1:0] argb_word;
		logic [ADDR_W-1:0] pixel_address;
	} res_t;

	typedef struct packed {
		logic [ROT_W-1:0]           rotation;
		logic signed [OFFSET_W-1:0] width_offset;
		logic signed [OFFSET_W-1:0] height_offset;
	} place_ctl_t;

endpackage

// File: rtl/yrp_if.sv
// ----------------------------------------------------------------------------
// yrp_if
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface yrp_pix_if;
	logic                           valid;
	logic                           ready;
	logic [yrp_pkg::SAMPLE_W-1:0]   luma;
	logic [yrp_pkg::SAMPLE_W-1:0]   chroma_u;
	logic [yrp_pkg::SAMPLE_W-1:0]   chroma_v;
	logic [yrp_pkg::COORD_W-1:0]    src_col;
	logic [yrp_pkg::COORD_W-1:0]    src_row;
	modport source(output valid, luma, chroma_u, chroma_v, src_col, src_row, input ready);
	modport sink(input valid, luma, chroma_u, chroma_v, src_col, src_row, output ready);
endinterface

interface yrp_res_if;
	logic                         valid;
	logic                         ready;
	logic [yrp_pkg::ARGB_W-1:0]   argb_word;
	logic [yrp_pkg::ADDR_W-1:0]   pixel_address;
	modport source(output valid, argb_word, pixel_address, input ready);
	modport sink(input valid, argb_word, pixel_address, output ready);
endinterface

interface yrp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [yrp_pkg::CFG_IDX_W-1:0]    index;
	logic [yrp_pkg::CFG_DATA_W-1:0]   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/yrp_color.sv
// ----------------------------------------------------------------------------
// yrp_color
// Fixed-point BT.601 conversion of one Y/U/V sample set to opaque ARGB.
// ----------------------------------------------------------------------------
module yrp_color (
	input  logic [yrp_pkg::SAMPLE_W-1:0] luma,
	input  logic [yrp_pkg::SAMPLE_W-1:0] chroma_u,
	input  logic [yrp_pkg::SAMPLE_W-1:0] chroma_v,
	output logic [yrp_pkg::ARGB_W-1:0]   argb_word
);

	localparam int CW = yrp_pkg::CHAN_W;
	localparam int PAD = CW - yrp_pkg::SAMPLE_W;

	logic [yrp_pkg::SAMPLE_W-1:0] y_floor;
	logic signed [CW-1:0]         ys, us, vs;
	logic signed [CW-1:0]         r_acc, g_acc, b_acc;
	logic [yrp_pkg::SAMPLE_W-1:0] r_byte, g_byte, b_byte;

	function automatic logic [yrp_pkg::SAMPLE_W-1:0] clamp_chan(
		input logic signed [yrp_pkg::CHAN_W-1:0] v
	);
		logic [yrp_pkg::SAMPLE_W-1:0] res;
		if (v < 0) begin
			res = '0;
		end else if (v > yrp_pkg::CHAN_MAX) begin
			res = '1;
		end else begin
			res = v[yrp_pkg::CHAN_SHIFT +: yrp_pkg::SAMPLE_W];
		end
		return res;
	endfunction

	always_comb begin
		y_floor = (luma < yrp_pkg::LUMA_OFS) ? '0 : luma - yrp_pkg::LUMA_OFS;
		ys = signed'({{PAD{1'b0}}, y_floor});
		us = signed'({{PAD{1'b0}}, chroma_u}) - yrp_pkg::CHROMA_OFS;
		vs = signed'({{PAD{1'b0}}, chroma_v}) - yrp_pkg::CHROMA_OFS;
		r_acc = yrp_pkg::K_Y * ys + yrp_pkg::K_VR * vs;
		g_acc = yrp_pkg::K_Y * ys - yrp_pkg::K_VG * vs - yrp_pkg::K_UG * us;
		b_acc = yrp_pkg::K_Y * ys + yrp_pkg::K_UB * us;
		r_byte = clamp_chan(r_acc);
		g_byte = clamp_chan(g_acc);
		b_byte = clamp_chan(b_acc);
		argb_word = {yrp_pkg::ALPHA, r_byte, g_byte, b_byte};
	end

endmodule

// File: rtl/yrp_place.sv
// ----------------------------------------------------------------------------
// yrp_place
// Rotation, offset placement, frame bound check and linear address.
// ----------------------------------------------------------------------------
module yrp_place #(
	parameter int DIM_W = 13
) (
	input  logic [yrp_pkg::COORD_W-1:0] src_col,
	input  logic [yrp_pkg::COORD_W-1:0] src_row,
	input  yrp_pkg::place_ctl_t         ctl,
	input  logic [DIM_W-1:0]            frame_w,
	input  logic [DIM_W-1:0]            frame_h,
	output logic                        keep,
	output logic [yrp_pkg::ADDR_W-1:0]  pixel_address
);

	localparam int PW     = yrp_pkg::POS_W;
	localparam int PAD    = PW - yrp_pkg::COORD_W;
	localparam int CMP_W  = (DIM_W > PW) ? DIM_W : PW;
	localparam int PROD_W = 2 * DIM_W;

	logic                 sideways;
	logic signed [PW-1:0] col_s, row_s, off_x, off_y, fx, fy;
	logic [DIM_W-1:0]     lim_x, lim_y, ix, iy, w_m1, h_m1;
	logic [DIM_W-1:0]     row_idx, col_term;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W:0]      sum;

	always_comb begin
		sideways = ctl.rotation inside {yrp_pkg::ROT_90, yrp_pkg::ROT_270};
		col_s = signed'({{PAD{1'b0}}, src_col});
		row_s = signed'({{PAD{1'b0}}, src_row});
		off_x = sideways ? PW'(ctl.height_offset) : PW'(ctl.width_offset);
		off_y = sideways ? PW'(ctl.width_offset) : PW'(ctl.height_offset);
		fx = col_s + off_x;
		fy = row_s + off_y;
		lim_x = sideways ? frame_h : frame_w;
		lim_y = sideways ? frame_w : frame_h;
		keep = !fx[PW-1] && !fy[PW-1]
			&& (CMP_W'(fx[PW-2:0]) < CMP_W'(lim_x))
			&& (CMP_W'(fy[PW-2:0]) < CMP_W'(lim_y));
		ix = fx[DIM_W-1:0];
		iy = fy[DIM_W-1:0];
		w_m1 = frame_w - DIM_W'(1);
		h_m1 = frame_h - DIM_W'(1);
		case (ctl.rotation)
			yrp_pkg::ROT_90: begin
				row_idx  = ix;
				col_term = w_m1 - iy;
			end
			yrp_pkg::ROT_180: begin
				row_idx  = h_m1 - iy;
				col_term = w_m1 - ix;
			end
			yrp_pkg::ROT_270: begin
				row_idx  = h_m1 - ix;
				col_term = w_m1 - iy;
			end
			default: begin
				row_idx  = iy;
				col_term = ix;
			end
		endcase
		prod = PROD_W'(row_idx) * PROD_W'(frame_w);
		sum = (PROD_W + 1)'(prod) + (PROD_W + 1)'(col_term);
		pixel_address = yrp_pkg::ADDR_W'(sum);
	end

endmodule

// File: rtl/yuv_to_argb_rotate_place_top.sv
// ----------------------------------------------------------------------------
// yuv_to_argb_rotate_place_top
// YUV pixel to opaque ARGB, placed in a rotated, offset output frame.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock unless result back-pressure fills both
// registers. A pixel sits in the input register while color conversion and
// placement run, and its result is then captured in the result register.
// Pixels that land outside the frame produce no result. Registers are
// written through the cfg channel, which is always ready; write them only
// while no pixel is in flight. Frame sizes above MAX_DIM saturate.
// ----------------------------------------------------------------------------
module yuv_to_argb_rotate_place_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	yrp_pix_if.sink   pix,
	yrp_res_if.source res,
	yrp_cfg_if.sink   cfg
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);

	logic [yrp_pkg::ROT_W-1:0]           rotation_q;
	logic [yrp_pkg::FRAME_W-1:0]         frame_width_q, frame_height_q;
	logic signed [yrp_pkg::OFFSET_W-1:0] width_offset_q, height_offset_q;

	logic            valid_s1, valid_s2;
	yrp_pkg::pix_t   pix_s1;
	yrp_pkg::res_t   res_s2;

	logic                      s2_free;
	logic                      keep;
	logic [DIM_W-1:0]          frame_w, frame_h;
	logic [yrp_pkg::ARGB_W-1:0] argb;
	logic [yrp_pkg::ADDR_W-1:0] addr;
	yrp_pkg::place_ctl_t       ctl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q      <= yrp_pkg::ROT_0;
			frame_width_q   <= yrp_pkg::FRAME_RST;
			frame_height_q  <= yrp_pkg::FRAME_RST;
			width_offset_q  <= '0;
			height_offset_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				yrp_pkg::CFG_ROTATION:      rotation_q      <= cfg.data[yrp_pkg::ROT_W-1:0];
				yrp_pkg::CFG_FRAME_WIDTH:   frame_width_q   <= cfg.data[yrp_pkg::FRAME_W-1:0];
				yrp_pkg::CFG_FRAME_HEIGHT:  frame_height_q  <= cfg.data[yrp_pkg::FRAME_W-1:0];
				yrp_pkg::CFG_WIDTH_OFFSET:  width_offset_q  <= signed'(cfg.data);
				yrp_pkg::CFG_HEIGHT_OFFSET: height_offset_q <= signed'(cfg.data);
				default: ;
			endcase
		end
	end

	always_comb begin
		frame_w = (32'(frame_width_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(frame_width_q);
		frame_h = (32'(frame_height_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(frame_height_q);
		ctl.rotation      = rotation_q;
		ctl.width_offset  = width_offset_q;
		ctl.height_offset = height_offset_q;
	end

	assign s2_free   = !valid_s2 || res.ready;
	assign pix.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			pix_s1 <= '{luma: pix.luma, chroma_u: pix.chroma_u, chroma_v: pix.chroma_v,
				src_col: pix.src_col, src_row: pix.src_row};
		end
	end

	yrp_color u_color (
		.luma      (pix_s1.luma),
		.chroma_u  (pix_s1.chroma_u),
		.chroma_v  (pix_s1.chroma_v),
		.argb_word (argb)
	);

	yrp_place #(
		.DIM_W (DIM_W)
	) u_place (
		.src_col       (pix_s1.src_col),
		.src_row       (pix_s1.src_row),
		.ctl           (ctl),
		.frame_w       (frame_w),
		.frame_h       (frame_h),
		.keep          (keep),
		.pixel_address (addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1 && keep) begin
			res_s2 <= '{argb_word: argb, pixel_address: addr};
		end
	end

	assign res.valid         = valid_s2;
	assign res.argb_word     = res_s2.argb_word;
	assign res.pixel_address = res_s2.pixel_address;

	a_rise_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a pixel in the input register");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.argb_word[yrp_pkg::ARGB_W-1 -: yrp_pkg::SAMPLE_W] == yrp_pkg::ALPHA))
		else $error("result word is not opaque");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pix.ready)
		else $error("input stalled with an empty input register");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |=> (valid_s1 && $stable(pix_s1)))
		else $error("stalled pixel lost from the input register");

endmodule

// File: dv/yuv_to_argb_rotate_place_top_tb.sv
// ----------------------------------------------------------------------------
// yuv_to_argb_rotate_place_top_tb
// Directed and random pixel traffic against a self-checking color and
// placement predictor, across rotations, frame sizes and placement offsets.
// ----------------------------------------------------------------------------
module yuv_to_argb_rotate_place_top_tb;
	import yrp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM = 4096;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int STALL_PCT = 13;
	localparam int PHASES = 12;
	localparam int PLAN_ROWS = 44;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
		pix_t                  px;
		logic                  typed;
		logic                  typed_hit;
		res_t                  typed_res;
	} plan_row_t;

	localparam pix_t NO_PIX = '0;
	localparam res_t NO_RES = '0;

	logic clk;
	logic arst_n;
	int   mismatches = 0;
	int   cycle_count = 0;
	bit   calm = 1'b0;

	logic [ROT_W-1:0]           cur_rot  = ROT_0;
	logic [FRAME_W-1:0]         cur_w    = FRAME_RST;
	logic [FRAME_W-1:0]         cur_h    = FRAME_RST;
	logic signed [OFFSET_W-1:0] cur_wofs = '0;
	logic signed [OFFSET_W-1:0] cur_hofs = '0;

	res_t placed_pixels_due[$];

	plan_row_t directed_plan [PLAN_ROWS] = '{
		'{1'b0, CFG_ROTATION, 14'd0, {8'd16, 8'd128, 8'd128, 12'd0, 12'd0},
			1'b1, 1'b1, {32'hff000000, 24'h000000}},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd255, 8'd128, 8'd128, 12'd4095, 12'd4095},
			1'b1, 1'b1, {32'hffffffff, 24'hffffff}},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd0, 8'd0, 8'd0, 12'd0, 12'd4095},
			1'b1, 1'b1, {32'hff009a00, 24'hfff000}},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd255, 8'd255, 8'd255, 12'd4095, 12'd0},
			1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd235, 8'd16, 8'd240, 12'd1234, 12'd2345},
			1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd81, 8'd90, 8'd240, 12'haaa, 12'h555},
			1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_FRAME_WIDTH, 14'd100, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_FRAME_HEIGHT, 14'd50, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_WIDTH_OFFSET, 14'd10, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_HEIGHT_OFFSET, 14'h3ffb, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd200, 8'd60, 8'd180, 12'd89, 12'd44},
			1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd100, 8'd100, 8'd100, 12'd90, 12'd0},
			1'b1, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd100, 8'd100, 8'd100, 12'd0, 12'd55},
			1'b1, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd100, 8'd100, 8'd100, 12'd0, 12'd4},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_ROTATION, 14'(ROT_90), NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd50, 8'd220, 8'd30, 12'd54, 12'd89},
			1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd50, 8'd220, 8'd30, 12'd55, 12'd0},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_ROTATION, 14'(ROT_180), NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd170, 8'd10, 8'd250, 12'd0, 12'd5},
			1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_ROTATION, 14'(ROT_270), NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd17, 8'd129, 8'd127, 12'd5, 12'd0},
			1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd17, 8'd129, 8'd127, 12'd0, 12'd90},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_WIDTH_OFFSET, 14'h2000, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd255, 8'd0, 8'd255, 12'd4095, 12'd4095},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_WIDTH_OFFSET, 14'h1fff, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd0, 8'd255, 8'd0, 12'd0, 12'd0},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_ROTATION, 14'(ROT_0), NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_WIDTH_OFFSET, 14'd0, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_HEIGHT_OFFSET, 14'd0, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_FRAME_WIDTH, 14'd8191, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_FRAME_HEIGHT, 14'd1, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd128, 8'd128, 8'd128, 12'd4095, 12'd0},
			1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd128, 8'd128, 8'd128, 12'd0, 12'd1},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_FRAME_WIDTH, 14'd0, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd128, 8'd128, 8'd128, 12'd0, 12'd0},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_UNUSED_LO, 14'h3fff, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_UNUSED_HI, 14'd0, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_FRAME_WIDTH, 14'd1, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd90, 8'd240, 8'd110, 12'd0, 12'd0},
			1'b0, 1'b0, NO_RES},
		'{1'b1, CFG_HEIGHT_OFFSET, 14'h1fff, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd90, 8'd240, 8'd110, 12'd0, 12'd0},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_HEIGHT_OFFSET, 14'h2000, NO_PIX, 1'b0, 1'b0, NO_RES},
		'{1'b0, CFG_ROTATION, 14'd0, {8'd90, 8'd240, 8'd110, 12'd0, 12'd0},
			1'b1, 1'b0, NO_RES},
		'{1'b1, CFG_HEIGHT_OFFSET, 14'd0, NO_PIX, 1'b0, 1'b0, NO_RES}
	};

	yrp_pix_if pix();
	yrp_res_if res();
	yrp_cfg_if cfg();

	yuv_to_argb_rotate_place_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix),
		.res   (res),
		.cfg   (cfg)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int eff_dim(logic [FRAME_W-1:0] d);
		return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	function automatic logic [7:0] chan8(int s);
		if (s < 0) s = 0;
		if (s > 262143) s = 262143;
		return 8'(s >> 10);
	endfunction

	function automatic bit convert_and_place(pix_t p, output res_t r);
		int  y, u, v, w, h, fx, fy, a;
		bit  sideways;
		r = '0;
		y = int'(p.luma) - 16;
		u = int'(p.chroma_u) - 128;
		v = int'(p.chroma_v) - 128;
		if (y < 0) y = 0;
		w = eff_dim(cur_w);
		h = eff_dim(cur_h);
		sideways = (cur_rot == ROT_90) || (cur_rot == ROT_270);
		fx = int'(p.src_col) + (sideways ? int'(cur_hofs) : int'(cur_wofs));
		fy = int'(p.src_row) + (sideways ? int'(cur_wofs) : int'(cur_hofs));
		if (sideways ? (fx < 0 || fx >= h || fy < 0 || fy >= w)
		             : (fx < 0 || fx >= w || fy < 0 || fy >= h))
			return 1'b0;
		r.argb_word = {8'hff, chan8(1192 * y + 1634 * v),
			chan8(1192 * y - 833 * v - 400 * u), chan8(1192 * y + 2066 * u)};
		case (cur_rot)
			ROT_90:  a = fx * w + (w - 1 - fy);
			ROT_180: a = (h - 1 - fy) * w + (w - 1 - fx);
			ROT_270: a = (h - 1 - fx) * w + (w - 1 - fy);
			default: a = fy * w + fx;
		endcase
		r.pixel_address = a[ADDR_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic [FRAME_W-1:0] pick_dim();
		case ($urandom_range(9))
			0: return 13'd1;
			1: return 13'd4096;
			2: return 13'd8191;
			3: return 13'd0;
			4, 5: return 13'($urandom_range(1, 64));
			default: return 13'($urandom_range(1, 4096));
		endcase
	endfunction

	function automatic logic [OFFSET_W-1:0] pick_offset();
		case ($urandom_range(9))
			0: return 14'h2000;
			1: return 14'h1fff;
			2, 3: return '0;
			4, 5: return 14'(int'($urandom_range(64)) - 32);
			default: return 14'(int'($urandom_range(8192)) - 4096);
		endcase
	endfunction

	// aim anywhere across the frame along one axis, or just past either edge
	function automatic logic [COORD_W-1:0] pick_coord(int span, int ofs);
		int t, c;
		t = int'($urandom_range(span + 1)) - 1;
		c = t - ofs;
		if (c < 0 || c > 4095) c = int'($urandom_range(4095));
		return c[COORD_W-1:0];
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH @%0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		pix.valid <= 1'b0;
		do @(posedge clk); while (placed_pixels_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_ROTATION:      cur_rot  = val[ROT_W-1:0];
			CFG_FRAME_WIDTH:   cur_w    = val[FRAME_W-1:0];
			CFG_FRAME_HEIGHT:  cur_h    = val[FRAME_W-1:0];
			CFG_WIDTH_OFFSET:  cur_wofs = val;
			CFG_HEIGHT_OFFSET: cur_hofs = val;
			default: ;
		endcase
	endtask

	task automatic send_pixel(pix_t p, bit typed, bit typed_hit, res_t typed_res);
		res_t want;
		bit   hit;
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid    <= 1'b1;
		pix.luma     <= p.luma;
		pix.chroma_u <= p.chroma_u;
		pix.chroma_v <= p.chroma_v;
		pix.src_col  <= p.src_col;
		pix.src_row  <= p.src_row;
		do @(posedge clk); while (!pix.ready);
		if (typed) begin
			hit  = typed_hit;
			want = typed_res;
		end else begin
			hit = convert_and_place(p, want);
		end
		if (hit) placed_pixels_due.push_back(want);
	endtask

	initial begin
		res_t due;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				if (placed_pixels_due.size() == 0) begin
					flag_mismatch("result with none pending", res.argb_word, '0);
				end else begin
					due = placed_pixels_due.pop_front();
					if (res.argb_word !== due.argb_word)
						flag_mismatch("argb_word", res.argb_word, due.argb_word);
					if (res.pixel_address !== due.pixel_address)
						flag_mismatch("pixel_address", 32'(res.pixel_address),
							32'(due.pixel_address));
				end
			end
			res.ready <= calm || ($urandom_range(99) >= STALL_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		pix_t             p;
		int               n, span_c, span_r, ofs_c, ofs_r;
		bit               sideways;
		logic [ROT_W-1:0] rot_seq [4];
		rot_seq = '{ROT_0, ROT_90, ROT_180, ROT_270};
		arst_n       <= 1'b0;
		pix.valid    <= 1'b0;
		pix.luma     <= '0;
		pix.chroma_u <= '0;
		pix.chroma_v <= '0;
		pix.src_col  <= '0;
		pix.src_row  <= '0;
		cfg.valid    <= 1'b0;
		cfg.index    <= '0;
		cfg.data     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (directed_plan[i].is_cfg)
				write_reg(directed_plan[i].index, directed_plan[i].data);
			else
				send_pixel(directed_plan[i].px, directed_plan[i].typed,
					directed_plan[i].typed_hit, directed_plan[i].typed_res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			calm = (ph == 5 || ph == 6);
			write_reg(CFG_ROTATION, 14'(rot_seq[ph % 4]));
			write_reg(CFG_FRAME_WIDTH, 14'(pick_dim()));
			write_reg(CFG_FRAME_HEIGHT, 14'(pick_dim()));
			write_reg(CFG_WIDTH_OFFSET, pick_offset());
			write_reg(CFG_HEIGHT_OFFSET, pick_offset());
			if (ph == 3) write_reg(CFG_UNUSED_LO, 14'($urandom));
			sideways = (cur_rot == ROT_90) || (cur_rot == ROT_270);
			span_c = sideways ? eff_dim(cur_h) : eff_dim(cur_w);
			span_r = sideways ? eff_dim(cur_w) : eff_dim(cur_h);
			ofs_c  = sideways ? int'(cur_hofs) : int'(cur_wofs);
			ofs_r  = sideways ? int'(cur_wofs) : int'(cur_hofs);
			n = (cur_w == 0 || cur_h == 0) ? 20 : 130;
			for (int i = 0; i < n; i++) begin
				if (ph == 8 && i == n / 2) begin
					pix.valid <= 1'b0;
					do @(posedge clk); while (placed_pixels_due.size() != 0);
				end
				p.luma     = 8'($urandom);
				p.chroma_u = 8'($urandom);
				p.chroma_v = 8'($urandom);
				if ($urandom_range(99) < 85) begin
					p.src_col = pick_coord(span_c, ofs_c);
					p.src_row = pick_coord(span_r, ofs_r);
				end else begin
					p.src_col = 12'($urandom);
					p.src_row = 12'($urandom);
				end
				send_pixel(p, 1'b0, 1'b0, NO_RES);
			end
		end
		calm = 1'b0;

		pix.valid <= 1'b0;
		while (placed_pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/yrp_pkg.sv
rtl/yrp_if.sv
rtl/yrp_color.sv
rtl/yrp_place.sv
rtl/yuv_to_argb_rotate_place_top.sv
dv/yuv_to_argb_rotate_place_top_tb.sv
